// ===== rtl/gregorian_date_navigator_macros.svh =====
// assertion macros shared by the date navigator rtl
`ifndef GREGORIAN_DATE_NAVIGATOR_MACROS_SVH
`define GREGORIAN_DATE_NAVIGATOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GDN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define GDN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gdn_pkg.sv =====
// types, constants and calendar functions of the date navigator
package gdn_pkg;

  typedef enum logic [2:0] {
    ACT_SET        = 3'd0,
    ACT_PREV_DAY   = 3'd1,
    ACT_NEXT_DAY   = 3'd2,
    ACT_PREV_WEEK  = 3'd3,
    ACT_NEXT_WEEK  = 3'd4,
    ACT_PREV_MONTH = 3'd5,
    ACT_NEXT_MONTH = 3'd6
  } action_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic  write;
    logic  at_limit;
    date_t date;
  } step_res_t;

  localparam logic [13:0] YearMin    = 14'd1;
  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [3:0]  MonthMin   = 4'd1;
  localparam logic [3:0]  MonthMax   = 4'd12;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [4:0]  DayMin     = 5'd1;
  localparam logic [4:0]  WeekDays   = 5'd7;
  localparam logic [26:0] YearScale  = 27'd10000;
  localparam logic [26:0] MonthScale = 27'd100;
  // inverse of 25 modulo 2^14, and the largest product a multiple of 25 maps to
  localparam logic [13:0] Inv25      = 14'd7209;
  localparam logic [13:0] Div25Max   = 14'd655;

  localparam date_t ResetDate = '{year: 14'd2000, month: 4'd1, day: 5'd1};

  // divisible by 400 is divisible by 16 and by 25
  function automatic logic is_leap(logic [13:0] y);
    logic [13:0] p;
    logic        div25;
    p     = 14'(y * Inv25);
    div25 = (p <= Div25Max);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in(logic [13:0] y, logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      MonthFeb: begin
        r = is_leap(y) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        r = 5'd30;
      end
      default: begin
        r = 5'd31;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gdn_in_if.sv =====
// input channel: navigation action and the date to load
interface gdn_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [13:0] set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;

  modport source (output valid, action, set_year, set_month, set_day, input ready);
  modport sink (input valid, action, set_year, set_month, set_day, output ready);
endinterface

// ===== rtl/gdn_out_if.sv =====
// output channel: current date after each step
interface gdn_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [26:0] packed_date;
  logic        at_limit;

  modport source (output valid, out_year, out_month, out_day, packed_date, at_limit,
                  input ready);
  modport sink (input valid, out_year, out_month, out_day, packed_date, at_limit,
                output ready);
endinterface

// ===== rtl/gdn_step.sv =====
// next-date logic for one navigation action
module gdn_step (
  input  gdn_pkg::date_t     cur_i,
  input  logic [2:0]         action_i,
  input  logic [13:0]        set_year_i,
  input  logic [3:0]         set_month_i,
  input  logic [4:0]         set_day_i,
  output gdn_pkg::step_res_t res_o
);

  typedef enum logic [1:0] {MV_STAY, MV_BACK, MV_FWD, MV_LOAD} move_e;

  move_e       move;
  logic        change;
  logic        limit;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_new;
  logic [4:0]  room;
  logic [13:0] new_year;
  logic [3:0]  new_month;
  logic [3:0]  set_month_c;
  logic [4:0]  set_day_c;
  logic [4:0]  raw_day;
  logic [4:0]  new_day;

  assign dim_cur = gdn_pkg::days_in(cur_i.year, cur_i.month);
  // days left in the current month after today
  assign room    = dim_cur - cur_i.day;

  assign set_month_c = (set_month_i < gdn_pkg::MonthMin) ? gdn_pkg::MonthMin :
                       (set_month_i > gdn_pkg::MonthMax) ? gdn_pkg::MonthMax : set_month_i;
  assign set_day_c   = (set_day_i < gdn_pkg::DayMin) ? gdn_pkg::DayMin : set_day_i;

  always_comb begin
    move   = MV_STAY;
    change = 1'b1;
    unique case (action_i)
      gdn_pkg::ACT_SET: begin
        move = MV_LOAD;
      end
      gdn_pkg::ACT_PREV_DAY: begin
        if (cur_i.day <= gdn_pkg::DayMin) move = MV_BACK;
      end
      gdn_pkg::ACT_NEXT_DAY: begin
        if (cur_i.day >= dim_cur) move = MV_FWD;
      end
      gdn_pkg::ACT_PREV_WEEK: begin
        if (cur_i.day <= gdn_pkg::WeekDays) move = MV_BACK;
      end
      gdn_pkg::ACT_NEXT_WEEK: begin
        if (room < gdn_pkg::WeekDays) move = MV_FWD;
      end
      gdn_pkg::ACT_PREV_MONTH: begin
        move = MV_BACK;
      end
      gdn_pkg::ACT_NEXT_MONTH: begin
        move = MV_FWD;
      end
      default: begin
        change = 1'b0;
      end
    endcase
  end

  always_comb begin
    new_year  = cur_i.year;
    new_month = cur_i.month;
    unique case (move)
      MV_LOAD: begin
        new_year  = set_year_i;
        new_month = set_month_c;
      end
      MV_BACK: begin
        if (cur_i.month <= gdn_pkg::MonthMin) begin
          new_month = gdn_pkg::MonthMax;
          new_year  = cur_i.year - 14'd1;
        end else begin
          new_month = cur_i.month - 4'd1;
        end
      end
      MV_FWD: begin
        if (cur_i.month >= gdn_pkg::MonthMax) begin
          new_month = gdn_pkg::MonthMin;
          new_year  = cur_i.year + 14'd1;
        end else begin
          new_month = cur_i.month + 4'd1;
        end
      end
      default: begin
        new_year  = cur_i.year;
        new_month = cur_i.month;
      end
    endcase
  end

  assign dim_new = gdn_pkg::days_in(new_year, new_month);

  always_comb begin
    unique case (action_i)
      gdn_pkg::ACT_SET: begin
        raw_day = set_day_c;
      end
      gdn_pkg::ACT_PREV_DAY: begin
        raw_day = (move == MV_BACK) ? dim_new : cur_i.day - 5'd1;
      end
      gdn_pkg::ACT_NEXT_DAY: begin
        raw_day = (move == MV_FWD) ? gdn_pkg::DayMin : cur_i.day + 5'd1;
      end
      gdn_pkg::ACT_PREV_WEEK: begin
        raw_day = (move == MV_BACK) ? dim_new - (gdn_pkg::WeekDays - cur_i.day)
                                    : cur_i.day - gdn_pkg::WeekDays;
      end
      gdn_pkg::ACT_NEXT_WEEK: begin
        raw_day = (move == MV_FWD) ? gdn_pkg::WeekDays - room
                                   : cur_i.day + gdn_pkg::WeekDays;
      end
      default: begin
        raw_day = cur_i.day;
      end
    endcase
  end

  assign new_day = (raw_day > dim_new) ? dim_new : raw_day;
  assign limit   = change && ((new_year < gdn_pkg::YearMin) || (new_year > gdn_pkg::YearMax));

  assign res_o.write      = change && !limit;
  assign res_o.at_limit   = limit;
  assign res_o.date.year  = new_year;
  assign res_o.date.month = new_month;
  assign res_o.date.day   = new_day;

endmodule

// ===== rtl/gregorian_date_navigator.sv =====
// gregorian date navigator top level: input register, date/result register
// a beat waits in the input register until the result stage can advance; its result is then registered
// throughput: one beat per cycle while out_o.ready does not stall; the date registers double as the result register
// the next-date logic plus the month-length lookup is the only path between them
// reset: date becomes 2000-01-01 and both stages are empty
`include "gregorian_date_navigator_macros.svh"

module gregorian_date_navigator (
  input  logic clk_i,
  input  logic rst_ni,
  gdn_in_if.sink    in_i,
  gdn_out_if.source out_o
);

  logic               in_v_q, in_v_d;
  logic [2:0]         act_q;
  logic [13:0]        set_year_q;
  logic [3:0]         set_month_q;
  logic [4:0]         set_day_q;
  logic               out_v_q, out_v_d;
  logic               lim_q, lim_d;
  gdn_pkg::date_t     cur_q, cur_d;
  gdn_pkg::step_res_t step_res;
  logic               adv;
  logic               step_en;
  logic               in_take;
  logic [4:0]         cur_dim;
  logic               date_ok;
  logic               refuse;

  gdn_step u_step (
    .cur_i       (cur_q),
    .action_i    (act_q),
    .set_year_i  (set_year_q),
    .set_month_i (set_month_q),
    .set_day_i   (set_day_q),
    .res_o       (step_res)
  );

  // result stage can take a new date when empty or draining
  assign adv       = !out_v_q || out_o.ready;
  assign step_en   = in_v_q && adv;
  assign in_i.ready = !in_v_q || adv;
  assign in_take   = in_i.valid && in_i.ready;

  assign in_v_d  = in_i.ready ? in_i.valid : in_v_q;
  assign out_v_d = adv ? in_v_q : out_v_q;
  assign cur_d   = (step_en && step_res.write) ? step_res.date : cur_q;
  assign lim_d   = step_en ? step_res.at_limit : lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cur_q   <= gdn_pkg::ResetDate;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q       <= in_i.action;
      set_year_q  <= in_i.set_year;
      set_month_q <= in_i.set_month;
      set_day_q   <= in_i.set_day;
    end
    lim_q <= lim_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.out_year    = cur_q.year;
  assign out_o.out_month   = cur_q.month;
  assign out_o.out_day     = cur_q.day;
  assign out_o.at_limit    = lim_q;
  assign out_o.packed_date = 27'(27'(cur_q.year) * gdn_pkg::YearScale)
                           + 27'(27'(cur_q.month) * gdn_pkg::MonthScale)
                           + 27'(cur_q.day);

  assign cur_dim = gdn_pkg::days_in(cur_q.year, cur_q.month);
  assign date_ok = (cur_q.year >= gdn_pkg::YearMin) && (cur_q.year <= gdn_pkg::YearMax)
                && (cur_q.month >= gdn_pkg::MonthMin) && (cur_q.month <= gdn_pkg::MonthMax)
                && (cur_q.day >= gdn_pkg::DayMin) && (cur_q.day <= cur_dim);
  assign refuse  = step_en && step_res.at_limit;

  `GDN_ASSERT(a_date_legal, date_ok, "current date left the legal range")
  `GDN_ASSERT_NEXT(a_hold_when_stalled, !step_en, $stable(cur_q), "date changed without a step")
  `GDN_ASSERT_NEXT(a_refused_keeps_date, refuse, $stable(cur_q) && lim_q, "date moved on a refusal")
  `GDN_ASSERT_NEXT(a_item_kept, in_v_q && !adv, in_v_q, "buffered beat dropped during stall")

endmodule
